// ===== rtl/base64_line_wrapping_encoder_top_macros.svh =====
// Assertion macros for the Base64 line-wrapping encoder.
`ifndef BASE64_LINE_WRAPPING_ENCODER_TOP_MACROS_SVH
`define BASE64_LINE_WRAPPING_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define B64LWE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("b64lwe assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define B64LWE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("b64lwe assertion failed");

`endif

// ===== rtl/b64lwe_pkg.sv =====
// Package with word types, constants and the alphabet function of the Base64 encoder.
`default_nettype none

package b64lwe_pkg;

  // Character codes and line-width limits.
  localparam logic [7:0] NEWLINE_CHAR     = 8'h0A;
  localparam logic [7:0] PAD_CHAR         = 8'h3D;
  localparam logic [7:0] LINE_WIDTH_RESET = 8'd72;
  localparam logic [7:0] COLUMN_MAX       = 8'd255;

  // Function codes of an input word.
  localparam logic FUNC_DATA = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  // Input word.
  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_word_t;

  // Output word.
  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_word_t;

  // Work handed from the group stage to the character emitter.
  typedef struct packed {
    logic [3:0][7:0] chars;     // chars[0] goes out first
    logic [2:0]      nchar;     // 0 or 4 characters
    logic            eom;       // end of message: column clears when done
    logic            final_nl;  // closing newline after the characters
  } job_t;

  // Map a sextet to its character in the standard alphabet.
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] r;
    r = 8'd0;
    if (v < 6'd26) begin
      r = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'd71 + {2'b00, v};
    end else if (v < 6'd62) begin
      r = {2'b00, v} - 8'd4;
    end else if (v == 6'd62) begin
      r = 8'd43;
    end else begin
      r = 8'd47;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/b64lwe_group.sv =====
// Group stage: collects bytes into 24-bit groups and registers the characters of each word.
`default_nettype none

module b64lwe_group (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  b64lwe_pkg::in_word_t in_word_i,
  input  logic [7:0]           line_width_i,
  output logic                 job_valid_o,
  output b64lwe_pkg::job_t     job_o,
  input  logic                 job_take_i
);
  import b64lwe_pkg::*;

  logic [15:0] pending_bits_q, pending_bits_d;
  logic [1:0]  pending_count_q, pending_count_d;
  logic        job_valid_q, job_valid_d;
  job_t        job_q, job_d;
  logic        accept;
  logic [23:0] grp;

  // A word is taken whenever the job register is empty or being emptied.
  assign in_stall_o = job_valid_q && !job_take_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Build the job of the incoming word and the next pending state.
  always_comb begin
    pending_bits_d  = pending_bits_q;
    pending_count_d = pending_count_q;
    job_d           = '0;
    grp             = '0;
    if (in_word_i.func == FUNC_DATA) begin
      if (pending_count_q >= 2'd2) begin
        grp             = {pending_bits_q, in_word_i.data_byte};
        job_d.chars[0]  = sextet_char(grp[23:18]);
        job_d.chars[1]  = sextet_char(grp[17:12]);
        job_d.chars[2]  = sextet_char(grp[11:6]);
        job_d.chars[3]  = sextet_char(grp[5:0]);
        job_d.nchar     = 3'd4;
        pending_bits_d  = '0;
        pending_count_d = '0;
      end else begin
        pending_bits_d  = {pending_bits_q[7:0], in_word_i.data_byte};
        pending_count_d = pending_count_q + 2'd1;
      end
    end else begin
      if (pending_count_q >= 2'd2) begin
        grp            = {6'd0, pending_bits_q, 2'b00};
        job_d.chars[0] = sextet_char(grp[17:12]);
        job_d.chars[1] = sextet_char(grp[11:6]);
        job_d.chars[2] = sextet_char(grp[5:0]);
        job_d.chars[3] = PAD_CHAR;
        job_d.nchar    = 3'd4;
      end else if (pending_count_q == 2'd1) begin
        grp            = {12'd0, pending_bits_q[7:0], 4'b0000};
        job_d.chars[0] = sextet_char(grp[11:6]);
        job_d.chars[1] = sextet_char(grp[5:0]);
        job_d.chars[2] = PAD_CHAR;
        job_d.chars[3] = PAD_CHAR;
        job_d.nchar    = 3'd4;
      end
      job_d.eom       = 1'b1;
      job_d.final_nl  = (line_width_i != 8'd0);
      pending_bits_d  = '0;
      pending_count_d = '0;
    end
  end

  assign job_valid_d = accept || (job_valid_q && !job_take_i);

  // Control and pending state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_bits_q  <= '0;
      pending_count_q <= '0;
      job_valid_q     <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      if (accept) begin
        pending_bits_q  <= pending_bits_d;
        pending_count_q <= pending_count_d;
      end
    end
  end

  // Job payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

endmodule

`default_nettype wire

// ===== rtl/b64lwe_emit.sv =====
// Character emitter: sends one character per cycle unless the output stalls, and inserts newlines at line ends.
`default_nettype none

module b64lwe_emit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            line_width_i,
  input  logic                  job_valid_i,
  input  b64lwe_pkg::job_t      job_i,
  output logic                  job_take_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output b64lwe_pkg::out_word_t out_word_o
);
  import b64lwe_pkg::*;

  job_t       cur_q;
  logic       busy_q, busy_d;
  logic [2:0] idx_q, idx_d;
  logic       nl_pend_q, nl_pend_d;
  logic       fin_pend_q, fin_pend_d;
  logic [7:0] col_q, col_d;
  logic       out_valid_q;
  out_word_t  out_word_q;

  logic       out_free, has_out, advance, done, load, wrap;
  logic [7:0] col_inc;
  logic [7:0] ch;

  assign out_free = !out_valid_q || !out_stall_i;
  assign has_out  = nl_pend_q || (idx_q < cur_q.nchar) || fin_pend_q;
  assign advance  = busy_q && (!has_out || out_free);
  assign col_inc  = (col_q == COLUMN_MAX) ? COLUMN_MAX : col_q + 8'd1;

  // One emission step: a pending line-end newline, then a character, then the closing newline.
  always_comb begin
    idx_d      = idx_q;
    nl_pend_d  = nl_pend_q;
    fin_pend_d = fin_pend_q;
    col_d      = col_q;
    ch         = NEWLINE_CHAR;
    wrap       = 1'b0;
    if (nl_pend_q) begin
      nl_pend_d = 1'b0;
    end else if (idx_q < cur_q.nchar) begin
      ch        = cur_q.chars[idx_q[1:0]];
      wrap      = (line_width_i != 8'd0) && (col_inc >= line_width_i);
      nl_pend_d = wrap;
      col_d     = wrap ? 8'd0 : col_inc;
      idx_d     = idx_q + 3'd1;
    end else begin
      fin_pend_d = 1'b0;
    end
    done = !(nl_pend_d || (idx_d < cur_q.nchar) || fin_pend_d);
    if (done && cur_q.eom) begin
      col_d = 8'd0;
    end
  end

  // The next job is loaded when idle or in the cycle the current one finishes.
  assign load       = job_valid_i && (!busy_q || (advance && done));
  assign job_take_o = load;
  assign busy_d     = busy_q ? (advance && done ? job_valid_i : 1'b1) : job_valid_i;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      nl_pend_q   <= 1'b0;
      fin_pend_q  <= 1'b0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (advance) begin
        col_q <= col_d;
      end
      if (load) begin
        idx_q      <= '0;
        nl_pend_q  <= 1'b0;
        fin_pend_q <= job_i.final_nl;
      end else if (advance) begin
        idx_q      <= idx_d;
        nl_pend_q  <= nl_pend_d;
        fin_pend_q <= fin_pend_d;
      end
      if (out_free) begin
        out_valid_q <= advance && has_out;
      end
    end
  end

  // Job and output payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= job_i;
    end
    if (advance && has_out) begin
      out_word_q.out_char <= ch;
      out_word_q.last     <= done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

// ===== rtl/base64_line_wrapping_encoder_top.sv =====
// Path: group job register, then the emitter's job register, then its output register.
// Throughput: one word can be taken every cycle while the job register is empty or being
// emptied; the emitter sends one character per cycle while the output is not stalled. The
// emitter's single output register sets this pace.
// Reset: asynchronous, active low; clears pending bytes, the column and all valid flags,
// and sets the line width to 72.
`default_nettype none
`include "base64_line_wrapping_encoder_top_macros.svh"

module base64_line_wrapping_encoder_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [7:0]            cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  b64lwe_pkg::in_word_t  in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output b64lwe_pkg::out_word_t out_word_o
);
  import b64lwe_pkg::*;

  logic [7:0] line_width_q;
  logic       job_valid;
  job_t       job;
  logic       job_take;

  // Line width register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LINE_WIDTH_RESET;
    end else if (cfg_we_i) begin
      line_width_q <= cfg_wdata_i;
    end
  end

  // Byte grouping stage.
  b64lwe_group u_group (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .line_width_i (line_width_q),
    .job_valid_o  (job_valid),
    .job_o        (job),
    .job_take_i   (job_take)
  );

  // Character emitter.
  b64lwe_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .line_width_i (line_width_q),
    .job_valid_i  (job_valid),
    .job_i        (job),
    .job_take_o   (job_take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_o   (out_word_o)
  );

  // With wrapping off, no newline word ever leaves the block.
  `B64LWE_ASSERT_IMP(a_no_nl_unwrapped, out_valid_o && (line_width_q == 8'd0), out_word_o.out_char != NEWLINE_CHAR)
  // An empty job register never holds off the input.
  `B64LWE_ASSERT_IMP(a_empty_no_stall, !job_valid, !in_stall_o)
  // A taken job leaves the register empty unless a new word came in.
  `B64LWE_ASSERT_NEXT(a_take_empties, job_take && !in_valid_i, !job_valid)

endmodule

`default_nettype wire

// ===== tb/base64_line_wrapping_encoder_top_tb.sv =====
// Self-checking testbench for the Base64 line-wrapping encoder with its own character predictor.
`timescale 1ns / 1ps

module base64_line_wrapping_encoder_top_tb;
  import b64lwe_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [8*64-1:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_word_t   in_word = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_word;

  // Stimulus pacing knobs and the long receiver hold-off.
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  logic       hold_start = 1'b0;
  int         hold_left = 0;

  // Predictor state: register copy, pending bytes, line column.
  logic [7:0]  width_q = LINE_WIDTH_RESET;
  logic [15:0] pend_bits = '0;
  logic [1:0]  pend_cnt = '0;
  logic [7:0]  line_col = '0;
  logic [7:0]  char_burst[$];
  out_word_t   expected_chars[$];
  out_word_t   oldest_char;

  int mismatches = 0;
  int words_taken = 0;
  int chars_checked = 0;
  int cycle_count = 0;

  base64_line_wrapping_encoder_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  // Clock with a 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Run guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles, %0d characters still due", $time,
               CYCLE_LIMIT, expected_chars.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off once requested.
  always @(posedge clk) begin
    if (hold_start) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [7:0] sextet_to_ascii(input logic [5:0] v);
    return B64_ALPHABET[8 * (63 - int'(v)) +: 8];
  endfunction

  // One character goes out; a newline follows when it fills the line.
  function automatic void put_char(input logic [7:0] ch);
    char_burst.push_back(ch);
    if (line_col != 8'd255) begin
      line_col = line_col + 8'd1;
    end
    if (width_q != 8'd0 && line_col >= width_q) begin
      char_burst.push_back(NEWLINE_CHAR);
      line_col = 8'd0;
    end
  endfunction

  // Work out the characters that one accepted word causes.
  function automatic void predict_chars(input in_word_t w);
    logic [23:0] grp;
    out_word_t   o;
    char_burst.delete();
    if (w.func == FUNC_DATA) begin
      if (pend_cnt == 2'd2) begin
        grp = {pend_bits, w.data_byte};
        put_char(sextet_to_ascii(grp[23:18]));
        put_char(sextet_to_ascii(grp[17:12]));
        put_char(sextet_to_ascii(grp[11:6]));
        put_char(sextet_to_ascii(grp[5:0]));
        pend_bits = '0;
        pend_cnt = 2'd0;
      end else begin
        pend_bits = {pend_bits[7:0], w.data_byte};
        pend_cnt = pend_cnt + 2'd1;
      end
    end else begin
      // End of message: flush with padding, then the closing newline.
      if (pend_cnt == 2'd2) begin
        grp = {6'd0, pend_bits, 2'b00};
        put_char(sextet_to_ascii(grp[17:12]));
        put_char(sextet_to_ascii(grp[11:6]));
        put_char(sextet_to_ascii(grp[5:0]));
        put_char(PAD_CHAR);
      end else if (pend_cnt == 2'd1) begin
        grp = {12'd0, pend_bits[7:0], 4'b0000};
        put_char(sextet_to_ascii(grp[11:6]));
        put_char(sextet_to_ascii(grp[5:0]));
        put_char(PAD_CHAR);
        put_char(PAD_CHAR);
      end
      if (width_q != 8'd0) begin
        char_burst.push_back(NEWLINE_CHAR);
      end
      pend_bits = '0;
      pend_cnt = 2'd0;
      line_col = 8'd0;
    end
    foreach (char_burst[i]) begin
      o.out_char = char_burst[i];
      o.last = (i == char_burst.size() - 1);
      expected_chars.push_back(o);
    end
  endfunction

  // Predict on every accepted input word, check every accepted output word.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_chars(in_word);
        words_taken++;
      end
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual char=%h last=%b", $time,
                   out_word.out_char, out_word.last);
          mismatches++;
        end else begin
          oldest_char = expected_chars.pop_front();
          if (out_word.out_char !== oldest_char.out_char) begin
            $display("%0t: out_char mismatch, expected %h, actual %h", $time,
                     oldest_char.out_char, out_word.out_char);
            mismatches++;
          end
          if (out_word.last !== oldest_char.last) begin
            $display("%0t: last mismatch on char %h, expected %b, actual %b", $time,
                     oldest_char.out_char, oldest_char.last, out_word.last);
            mismatches++;
          end
          chars_checked++;
        end
      end
    end
  end

  // Offer one word, with random idle cycles ahead of it, and wait until it is taken.
  task automatic send_word(input logic f, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= '{func: f, data_byte: b};
    do begin
      @(posedge clk);
    end while (in_stall);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_word(FUNC_DATA, s[i]);
    end
  endtask

  // Drop valid and let every expected character drain, plus a few quiet cycles.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(input logic [7:0] w);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    width_q = w;
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(9);
    if (r == 0) begin
      return 8'h00;
    end else if (r == 1) begin
      return 8'hFF;
    end
    return 8'($urandom_range(255));
  endfunction

  // Mostly whole messages of random length; some runs of loose words.
  task automatic send_random_traffic(input int n_words);
    int sent;
    int len;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(99) < 85) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
        for (int k = 0; k < len; k++) begin
          send_word(FUNC_DATA, pick_byte());
        end
        send_word(FUNC_END, pick_byte());
        sent += len + 1;
      end else begin
        len = $urandom_range(4, 1);
        for (int k = 0; k < len; k++) begin
          send_word(1'($urandom_range(1)), pick_byte());
        end
        sent += len;
      end
    end
  endtask

  // Default width after reset: full group, both padding forms, empty message, extreme bytes.
  task automatic test_reset_width();
    send_text("Man");
    send_word(FUNC_END, 8'h00);
    send_text("Ma");
    send_word(FUNC_END, 8'hFF);
    send_text("M");
    send_word(FUNC_END, 8'h00);
    send_word(FUNC_END, 8'hFF);
    send_word(FUNC_DATA, 8'h00);
    send_word(FUNC_DATA, 8'hFF);
    send_word(FUNC_DATA, 8'h80);
    send_word(FUNC_DATA, 8'h7F);
    send_word(FUNC_END, 8'h55);
  endtask

  // Narrow, widest and disabled wrapping.
  task automatic test_wrap_edges();
    // The line fills on the last character, so the message ends with an empty line.
    write_width(8'd4);
    send_text("Man");
    send_word(FUNC_END, 8'hAA);
    // Width of one with a single pending byte gives the longest burst.
    write_width(8'd1);
    send_text("M");
    send_word(FUNC_END, 8'h00);
    write_width(8'd255);
    send_text("xyz");
    send_word(FUNC_END, 8'h00);
    // Wrapping off: an empty message gives nothing at all.
    write_width(8'd0);
    send_word(FUNC_END, 8'h00);
    send_text("ab");
    send_word(FUNC_END, 8'hFF);
  endtask

  // Lower the width while the column is already past it.
  task automatic test_width_lowered();
    write_width(8'd72);
    send_text("abcdef");
    write_width(8'd5);
    send_text("ghi");
    send_word(FUNC_END, 8'h00);
  endtask

  // With wrapping off the column saturates; a later width ends the line at once.
  task automatic test_column_saturation();
    send_idle_pct = 35;
    stall_pct = 35;
    write_width(8'd0);
    for (int g = 0; g < 65 * 3; g++) begin
      send_word(FUNC_DATA, pick_byte());
    end
    write_width(8'd9);
    send_text("abc");
    send_word(FUNC_END, 8'h00);
  endtask

  // Random messages under each idling pattern, with a fresh width per phase.
  task automatic test_random_traffic();
    logic [7:0] w;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 68;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 68;
        end
        default: begin
          send_idle_pct = 35;
          stall_pct = 35;
        end
      endcase
      case ($urandom_range(5))
        0: w = 8'd0;
        1: w = 8'd1;
        2: w = 8'($urandom_range(8, 2));
        3: w = 8'd76;
        4: w = 8'd255;
        default: w = 8'($urandom_range(255));
      endcase
      write_width(w);
      send_random_traffic(20);
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering words.
  task automatic test_back_pressure();
    send_idle_pct = 0;
    stall_pct = 0;
    write_width(8'($urandom_range(12, 2)));
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    send_random_traffic(40);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_width();
    test_wrap_edges();
    test_width_lowered();
    test_column_saturation();
    test_random_traffic();
    test_back_pressure();
    wait_idle();
    $display("Run covered %0d input words and %0d checked characters over widths 0 to 255,",
             words_taken, chars_checked);
    $display("padding, column saturation, mid-line width change and a long output hold-off.");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
